FILE: hdl/esc_pkg.sv
package esc_pkg;

    localparam logic [31:0] TAG_FILE_HDR  = 32'hCBDFCBDF;
    localparam logic [31:0] TAG_EVENT_HDR = 32'hCBEDCBED;
    localparam logic [31:0] TAG_EVENT_TRL = 32'hDEBCDEBC;
    localparam logic [31:0] TAG_FILE_TRL  = 32'hFDBCFDBC;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    // Result kinds.
    localparam logic [2:0] KIND_FILE_OK  = 3'd0;
    localparam logic [2:0] KIND_BANK     = 3'd1;
    localparam logic [2:0] KIND_EVENT_OK = 3'd2;
    localparam logic [2:0] KIND_EOF      = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_FILE_HDR  = 3'd0;
    localparam logic [2:0] ERR_EVENT_HDR = 3'd1;
    localparam logic [2:0] ERR_MISMATCH  = 3'd2;
    localparam logic [2:0] ERR_CRC       = 3'd3;
    localparam logic [2:0] ERR_BANK      = 3'd4;
    localparam logic [2:0] ERR_END       = 3'd5;

    // Section header lengths and field positions.
    localparam logic [63:0] FILE_HDR_LAST  = 64'd59;
    localparam logic [63:0] EVENT_HDR_LAST = 64'd31;
    localparam logic [63:0] EVENT_TRL_LAST = 64'd19;
    localparam logic [63:0] FILE_TRL_LAST  = 64'd27;
    localparam logic [4:0]  BANK_HDR_LAST  = 5'd19;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        SEC_FILE_HDR,
        SEC_EV_HDR,
        SEC_PAYLOAD,
        SEC_EV_TRL,
        SEC_FILE_TRL,
        SEC_DONE
    } section_t;

    typedef enum logic [2:0] {
        OP_PAYLOAD,
        OP_EV_START,
        OP_FILE_HDR,
        OP_EV_HDR_BAD,
        OP_EV_TRL,
        OP_FILE_TRL,
        OP_END
    } op_kind_t;

    // One classified request handed from the front to the back.
    typedef struct packed {
        op_kind_t    op;
        logic        ok;
        logic [7:0]  data;
        logic [63:0] value;
        logic [63:0] event_number;
        logic [63:0] user_flags;
        logic [63:0] payload_size;
    } esc_op_t;

    function automatic logic [31:0] set_lane32(logic [31:0] r, logic [1:0] lane,
                                               logic [7:0] b);
        logic [31:0] res;
        res = r;
        for (int i = 0; i < 4; i++)
        begin
            if (lane == i[1:0])
            begin
                res[i*8 +: 8] = b;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] set_lane64(logic [63:0] r, logic [2:0] lane,
                                               logic [7:0] b);
        logic [63:0] res;
        res = r;
        for (int i = 0; i < 8; i++)
        begin
            if (lane == i[2:0])
            begin
                res[i*8 +: 8] = b;
            end
        end
        return res;
    endfunction

endpackage

FILE: hdl/esc_if.sv
interface esc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       stream_end;

    modport source (output valid, byte_value, stream_end, input ready);
    modport sink (input valid, byte_value, stream_end, output ready);
endinterface

interface esc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [63:0] event_number;
    logic [63:0] user_flags;
    logic [63:0] length_bytes;
    logic [15:0] bank_flags;
    logic [63:0] bank_offset;
    logic [63:0] name_low;
    logic [31:0] name_high;
    logic [31:0] checksum;

    modport source (output valid, kind, error_code, event_number, user_flags,
                    length_bytes, bank_flags, bank_offset, name_low, name_high,
                    checksum, input ready);
    modport sink (input valid, kind, error_code, event_number, user_flags,
                  length_bytes, bank_flags, bank_offset, name_low, name_high,
                  checksum, output ready);
endinterface

FILE: hdl/event_stream_checker.sv
// Channel   Dir  Payload                                            Request
// bytes     in   byte_value[7:0], stream_end                        one stream byte
// results   out  kind, error_code, event_number, user_flags,        one check result
//                length_bytes, bank_flags, bank_offset, name_low,
//                name_high, checksum
//
// One byte request is taken per cycle while the queue is not full; the front
// classifies it in the same cycle and writes it into the queue, and the back
// takes it from the queue and forms any result in the output register.
// The front tracks the file sections and header fields; the back keeps the
// payload CRC-32 (one byte per cycle unless the result output stalls) and the bank parser.
// Reset (rst_n low, asynchronous) returns to the file header and empties the queue.
// A stalled result output blocks the back; the four-entry queue then fills
// and the byte input drops ready only when the queue is full.
module event_stream_checker
    import esc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    esc_in_if.sink    bytes,
    esc_out_if.source results
);

    // Classified requests travel from the front to the back through a
    // short queue, so a stalled output does not immediately stop input.
    logic    push;
    esc_op_t push_data;
    logic    full;
    logic    head_valid;
    esc_op_t head_data;
    logic    pop;

    // The front owns the section state machine and all header and trailer
    // fields; it reports section ends and payload bytes as requests.
    esc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    esc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    // The back runs the CRC and bank parsing and forms every result in an
    // output register, taking the next request while a result is taken.
    esc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .results    (results)
    );

endmodule

FILE: hdl/esc_front.sv
module esc_front
    import esc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    esc_in_if.sink    bytes,
    input  logic      full,
    output logic      push,
    output esc_op_t   push_data
);

    section_t    section_reg, section_next;
    logic [63:0] count_reg, count_next;
    logic [31:0] open_reg, open_next;
    logic [31:0] close_reg, close_next;
    logic [63:0] evnum_reg, evnum_next;
    logic [63:0] flags_reg, flags_next;
    logic [63:0] psize_reg, psize_next;
    logic [63:0] tsize_reg, tsize_next;
    logic [31:0] tcrc_reg, tcrc_next;

    logic        accept;
    logic [7:0]  b;
    logic [63:0] p_inc;
    logic [2:0]  lane_hdr;

    assign bytes.ready = !full;
    assign accept = bytes.valid && !full;
    assign b = bytes.byte_value;
    assign p_inc = count_reg + 64'd1;
    // Event header fields start at offsets 4, 12 and 20, all 4 mod 8.
    assign lane_hdr = count_reg[2:0] - 3'd4;

    always_comb
    begin
        section_next = section_reg;
        count_next   = count_reg;
        open_next    = open_reg;
        close_next   = close_reg;
        evnum_next   = evnum_reg;
        flags_next   = flags_reg;
        psize_next   = psize_reg;
        tsize_next   = tsize_reg;
        tcrc_next    = tcrc_reg;
        push         = 1'b0;
        push_data.op           = OP_PAYLOAD;
        push_data.ok           = 1'b0;
        push_data.data         = b;
        push_data.value        = p_inc;
        push_data.event_number = evnum_reg;
        push_data.user_flags   = flags_reg;
        push_data.payload_size = psize_reg;

        if (accept && section_reg != SEC_DONE)
        begin
            count_next = p_inc;
            if (bytes.stream_end)
            begin
                section_next = SEC_DONE;
                push = 1'b1;
                push_data.op = OP_END;
                count_next = count_reg;
            end
            else
            begin
                case (section_reg)
                    SEC_FILE_HDR:
                    begin
                        if (count_reg < 64'd4)
                        begin
                            open_next = set_lane32(open_reg, count_reg[1:0], b);
                        end
                        else if (count_reg >= 64'd56)
                        begin
                            close_next = set_lane32(close_reg, count_reg[1:0], b);
                        end
                        if (count_reg == FILE_HDR_LAST)
                        begin
                            section_next = SEC_EV_HDR;
                            count_next = '0;
                            push = 1'b1;
                            push_data.op = OP_FILE_HDR;
                            push_data.ok = (open_next & close_next) == TAG_FILE_HDR;
                        end
                    end
                    SEC_EV_HDR:
                    begin
                        if (count_reg < 64'd4)
                        begin
                            open_next = set_lane32(open_reg, count_reg[1:0], b);
                        end
                        else if (count_reg < 64'd12)
                        begin
                            evnum_next = set_lane64(evnum_reg, lane_hdr, b);
                        end
                        else if (count_reg < 64'd20)
                        begin
                            flags_next = set_lane64(flags_reg, lane_hdr, b);
                        end
                        else if (count_reg < 64'd28)
                        begin
                            psize_next = set_lane64(psize_reg, lane_hdr, b);
                        end
                        else
                        begin
                            close_next = set_lane32(close_reg, count_reg[1:0], b);
                        end
                        if (count_reg == EVENT_HDR_LAST)
                        begin
                            count_next = '0;
                            if ((open_reg & close_next) == TAG_EVENT_HDR)
                            begin
                                push = 1'b1;
                                push_data.op = OP_EV_START;
                                section_next = (psize_reg == 64'd0) ? SEC_EV_TRL
                                                                    : SEC_PAYLOAD;
                            end
                            else if (open_reg == TAG_FILE_TRL)
                            begin
                                section_next = SEC_FILE_TRL;
                            end
                            else
                            begin
                                push = 1'b1;
                                push_data.op = OP_EV_HDR_BAD;
                            end
                        end
                    end
                    SEC_PAYLOAD:
                    begin
                        push = 1'b1;
                        push_data.op = OP_PAYLOAD;
                        if (p_inc == psize_reg)
                        begin
                            section_next = SEC_EV_TRL;
                            count_next = '0;
                        end
                    end
                    SEC_EV_TRL:
                    begin
                        if (count_reg < 64'd4)
                        begin
                            open_next = set_lane32(open_reg, count_reg[1:0], b);
                        end
                        else if (count_reg < 64'd8)
                        begin
                            tcrc_next = set_lane32(tcrc_reg, count_reg[1:0], b);
                        end
                        else if (count_reg < 64'd16)
                        begin
                            tsize_next = set_lane64(tsize_reg, count_reg[2:0], b);
                        end
                        else
                        begin
                            close_next = set_lane32(close_reg, count_reg[1:0], b);
                        end
                        if (count_reg == EVENT_TRL_LAST)
                        begin
                            section_next = SEC_EV_HDR;
                            count_next = '0;
                            push = 1'b1;
                            push_data.op = OP_EV_TRL;
                            push_data.ok = ((open_reg & close_next) == TAG_EVENT_TRL)
                                           && (psize_reg == tsize_reg);
                            push_data.value = {32'd0, tcrc_reg};
                        end
                    end
                    SEC_FILE_TRL:
                    begin
                        if (count_reg >= 64'd24)
                        begin
                            close_next = set_lane32(close_reg, count_reg[1:0], b);
                        end
                        if (count_reg == FILE_TRL_LAST)
                        begin
                            section_next = SEC_DONE;
                            push = 1'b1;
                            push_data.op = OP_FILE_TRL;
                            push_data.ok = (open_reg & close_next) == TAG_FILE_TRL;
                        end
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg <= SEC_FILE_HDR;
            count_reg   <= '0;
            open_reg    <= '0;
            close_reg   <= '0;
            evnum_reg   <= '0;
            flags_reg   <= '0;
            psize_reg   <= '0;
            tsize_reg   <= '0;
            tcrc_reg    <= '0;
        end
        else
        begin
            section_reg <= section_next;
            count_reg   <= count_next;
            open_reg    <= open_next;
            close_reg   <= close_next;
            evnum_reg   <= evnum_next;
            flags_reg   <= flags_next;
            psize_reg   <= psize_next;
            tsize_reg   <= tsize_next;
            tcrc_reg    <= tcrc_next;
        end
    end

    // Once stopped, the front never leaves the stopped section.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        section_reg == SEC_DONE |=> section_reg == SEC_DONE)
        else $error("front left the stopped section");

    // Nothing is queued once the stream has stopped.
    a_no_push_done: assert property (@(posedge clk) disable iff (!rst_n)
        section_reg == SEC_DONE |-> !push)
        else $error("request queued after stop");

endmodule

FILE: hdl/esc_queue.sv
module esc_queue
    import esc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  esc_op_t push_data,
    output logic    full,
    output logic    head_valid,
    output esc_op_t head_data,
    input  logic    pop
);

    esc_op_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_pop;

    assign full       = cnt_reg == QCNT_W'(QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_data  = mem_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && cnt_reg != QCNT_W'(QDEPTH)) |-> wr_reg != rd_reg)
        else $error("queue pointers disagree with count");

endmodule

FILE: hdl/esc_back.sv
module esc_back
    import esc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  esc_op_t   head_data,
    output logic      pop,
    esc_out_if.source results
);

    logic [31:0] crc_reg, crc_next;
    logic        in_hdr_reg, in_hdr_next;
    logic [4:0]  bcount_reg, bcount_next;
    logic [31:0] brem_reg, brem_next;
    logic [15:0] bflags_reg, bflags_next;
    logic [7:0]  name_reg [12];

    logic        ovalid_reg, ovalid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  err_reg, err_next;
    logic [63:0] evnum_reg, evnum_next;
    logic [63:0] uflags_reg, uflags_next;
    logic [63:0] len_reg, len_next;
    logic [15:0] oflags_reg, oflags_next;
    logic [63:0] off_reg, off_next;
    logic [63:0] nlo_reg, nlo_next;
    logic [31:0] nhi_reg, nhi_next;
    logic [31:0] csum_reg, csum_next;

    logic        name_we;
    logic [31:0] crc_byte;
    logic [31:0] crc_final;

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'd0, d};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    assign pop       = head_valid && (!ovalid_reg || results.ready);
    assign crc_byte  = crc_step(crc_reg, head_data.data);
    assign crc_final = ~crc_reg;

    always_comb
    begin
        crc_next    = crc_reg;
        in_hdr_next = in_hdr_reg;
        bcount_next = bcount_reg;
        brem_next   = brem_reg;
        bflags_next = bflags_reg;
        name_we     = 1'b0;
        ovalid_next = ovalid_reg && !results.ready;
        kind_next   = kind_reg;
        err_next    = err_reg;
        evnum_next  = evnum_reg;
        uflags_next = uflags_reg;
        len_next    = len_reg;
        oflags_next = oflags_reg;
        off_next    = off_reg;
        nlo_next    = nlo_reg;
        nhi_next    = nhi_reg;
        csum_next   = csum_reg;

        if (pop)
        begin
            // Fields common to every result.
            kind_next   = KIND_ERROR;
            err_next    = ERR_FILE_HDR;
            evnum_next  = head_data.event_number;
            uflags_next = head_data.user_flags;
            len_next    = head_data.payload_size;
            oflags_next = '0;
            off_next    = '0;
            nlo_next    = '0;
            nhi_next    = '0;
            csum_next   = '0;
            ovalid_next = 1'b1;
            case (head_data.op)
                OP_PAYLOAD:
                begin
                    ovalid_next = 1'b0;
                    crc_next = crc_byte;
                    if (!in_hdr_reg)
                    begin
                        brem_next = brem_reg - 32'd1;
                        if (brem_reg == 32'd1)
                        begin
                            in_hdr_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (bcount_reg < 5'd12)
                        begin
                            name_we = 1'b1;
                        end
                        else if (bcount_reg < 5'd14)
                        begin
                            bflags_next = bcount_reg[0]
                                ? {head_data.data, bflags_reg[7:0]}
                                : {bflags_reg[15:8], head_data.data};
                        end
                        else if (bcount_reg >= 5'd16)
                        begin
                            brem_next = set_lane32(brem_reg, bcount_reg[1:0],
                                                   head_data.data);
                        end
                        bcount_next = bcount_reg + 5'd1;
                        if (bcount_reg == BANK_HDR_LAST)
                        begin
                            bcount_next = '0;
                            in_hdr_next = brem_next == 32'd0;
                            ovalid_next = 1'b1;
                            kind_next   = KIND_BANK;
                            len_next    = {32'd0, brem_next};
                            oflags_next = bflags_reg;
                            off_next    = head_data.value;
                            nlo_next    = {name_reg[7], name_reg[6], name_reg[5],
                                           name_reg[4], name_reg[3], name_reg[2],
                                           name_reg[1], name_reg[0]};
                            nhi_next    = {name_reg[11], name_reg[10], name_reg[9],
                                           name_reg[8]};
                        end
                    end
                end
                OP_EV_START:
                begin
                    ovalid_next = 1'b0;
                    crc_next    = '1;
                    in_hdr_next = 1'b1;
                    bcount_next = '0;
                    brem_next   = '0;
                end
                OP_FILE_HDR:
                begin
                    kind_next = head_data.ok ? KIND_FILE_OK : KIND_ERROR;
                end
                OP_EV_HDR_BAD:
                begin
                    err_next = ERR_EVENT_HDR;
                end
                OP_EV_TRL:
                begin
                    csum_next = crc_final;
                    if (!head_data.ok)
                    begin
                        err_next = ERR_MISMATCH;
                    end
                    else if (crc_final != head_data.value[31:0])
                    begin
                        err_next = ERR_CRC;
                    end
                    else if (!in_hdr_reg || bcount_reg != 5'd0)
                    begin
                        err_next = ERR_BANK;
                    end
                    else
                    begin
                        kind_next = KIND_EVENT_OK;
                    end
                end
                OP_FILE_TRL:
                begin
                    if (head_data.ok)
                    begin
                        kind_next = KIND_EOF;
                    end
                    else
                    begin
                        err_next = ERR_END;
                    end
                end
                OP_END:
                begin
                    err_next = ERR_END;
                end
                default:
                begin
                    ovalid_next = 1'b0;
                end
            endcase
            if (kind_next != KIND_ERROR)
            begin
                err_next = ERR_FILE_HDR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_reg[bcount_reg[3:0]] <= head_data.data;
        end
        kind_reg   <= kind_next;
        err_reg    <= err_next;
        evnum_reg  <= evnum_next;
        uflags_reg <= uflags_next;
        len_reg    <= len_next;
        oflags_reg <= oflags_next;
        off_reg    <= off_next;
        nlo_reg    <= nlo_next;
        nhi_reg    <= nhi_next;
        csum_reg   <= csum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= '1;
            in_hdr_reg <= 1'b1;
            bcount_reg <= '0;
            brem_reg   <= '0;
            bflags_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            in_hdr_reg <= in_hdr_next;
            bcount_reg <= bcount_next;
            brem_reg   <= brem_next;
            bflags_reg <= bflags_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign results.valid        = ovalid_reg;
    assign results.kind         = kind_reg;
    assign results.error_code   = err_reg;
    assign results.event_number = evnum_reg;
    assign results.user_flags   = uflags_reg;
    assign results.length_bytes = len_reg;
    assign results.bank_flags   = oflags_reg;
    assign results.bank_offset  = off_reg;
    assign results.name_low     = nlo_reg;
    assign results.name_high    = nhi_reg;
    assign results.checksum     = csum_reg;

    a_bcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        bcount_reg <= BANK_HDR_LAST)
        else $error("bank header index out of range");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_hdr_reg |-> brem_reg != 32'd0)
        else $error("bank data phase with nothing left");

    a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !in_hdr_reg |-> bcount_reg == 5'd0)
        else $error("bank header index moved during bank data");

endmodule

FILE: tb/testbench.sv
module testbench;
    import esc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One observed or predicted check result, field by field.
    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  error_code;
        logic [63:0] event_number;
        logic [63:0] user_flags;
        logic [63:0] length_bytes;
        logic [15:0] bank_flags;
        logic [63:0] bank_offset;
        logic [63:0] name_low;
        logic [31:0] name_high;
        logic [31:0] checksum;
    } check_result_t;

    // Reflected CRC-32 over one byte, shared by the stream builder and the tracker.
    function automatic bit [31:0] crc32_next(bit [31:0] c, bit [7:0] b);
        c = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bit [63:0] put_byte(bit [63:0] r, bit [63:0] lane, bit [7:0] b);
        r[lane[2:0]*8 +: 8] = b;
        return r;
    endfunction

    // The stream tracker follows the file section by section, exactly as the
    // block should, and keeps the results it predicts in arrival order.
    class stream_tracker;
        section_t      sec;
        bit [63:0]     cnt;
        bit [31:0]     open_tag;
        bit [63:0]     close_tag;
        bit [63:0]     ev_number;
        bit [63:0]     ev_flags;
        bit [63:0]     pay_size;
        bit [63:0]     trl_size;
        bit [31:0]     crc;
        bit [31:0]     trl_crc;
        bit            in_bank_hdr;
        bit [31:0]     bank_idx;
        bit [31:0]     bank_left;
        bit [7:0]      bank_name [12];
        bit [15:0]     bank_flag;
        check_result_t pending [$];
        int            errors;

        function new();
            sec = SEC_FILE_HDR;
            cnt = 0;
            open_tag = 0;
            close_tag = 0;
            ev_number = 0;
            ev_flags = 0;
            pay_size = 0;
            trl_size = 0;
            crc = '1;
            trl_crc = 0;
            in_bank_hdr = 1;
            bank_idx = 0;
            bank_left = 0;
            bank_flag = 0;
            errors = 0;
            foreach (bank_name[i]) bank_name[i] = 0;
        endfunction

        function check_result_t make(logic [2:0] kind, logic [2:0] code, bit with_crc);
            check_result_t r;
            r.kind = kind;
            r.error_code = (kind == KIND_ERROR) ? code : ERR_FILE_HDR;
            r.event_number = ev_number;
            r.user_flags = ev_flags;
            r.length_bytes = pay_size;
            r.bank_flags = 0;
            r.bank_offset = 0;
            r.name_low = 0;
            r.name_high = 0;
            r.checksum = with_crc ? ~crc : 32'd0;
            return r;
        endfunction

        // A payload byte feeds the CRC and the bank parser.
        function void take_payload(bit [7:0] b);
            check_result_t r;
            bit [63:0]     data_off;
            crc = crc32_next(crc, b);
            cnt++;
            if (cnt == pay_size)
            begin
                sec = SEC_EV_TRL;
                cnt = 0;
            end
            if (!in_bank_hdr)
            begin
                bank_left--;
                if (bank_left == 0)
                begin
                    in_bank_hdr = 1;
                end
                return;
            end
            if (bank_idx < 12)
            begin
                bank_name[bank_idx] = b;
            end
            else if (bank_idx < 14)
            begin
                bank_flag = 16'(put_byte(64'(bank_flag), 64'(bank_idx - 12), b));
            end
            else if (bank_idx >= 16)
            begin
                bank_left = 32'(put_byte(64'(bank_left), 64'(bank_idx - 16), b));
            end
            bank_idx++;
            if (bank_idx < 20)
            begin
                return;
            end
            bank_idx = 0;
            data_off = (sec == SEC_EV_TRL) ? pay_size : cnt;
            in_bank_hdr = (bank_left == 0);
            r = make(KIND_BANK, ERR_FILE_HDR, 0);
            r.length_bytes = 64'(bank_left);
            r.bank_flags = bank_flag;
            r.bank_offset = data_off;
            for (int i = 0; i < 8; i++) r.name_low[i*8 +: 8] = bank_name[i];
            for (int i = 0; i < 4; i++) r.name_high[i*8 +: 8] = bank_name[8 + i];
            pending.push_back(r);
        endfunction

        // Notes one accepted byte request and predicts what it completes.
        function void note_byte(bit [7:0] b, bit fin);
            if (sec == SEC_DONE)
            begin
                return;
            end
            if (fin)
            begin
                sec = SEC_DONE;
                pending.push_back(make(KIND_ERROR, ERR_END, 0));
                return;
            end
            case (sec)
                SEC_FILE_HDR:
                begin
                    if (cnt < 4) open_tag = 32'(put_byte(64'(open_tag), cnt, b));
                    else if (cnt >= 56) close_tag = put_byte(close_tag, cnt - 56, b);
                    cnt++;
                    if (cnt == 60)
                    begin
                        sec = SEC_EV_HDR;
                        cnt = 0;
                        if ((open_tag & close_tag[31:0]) == TAG_FILE_HDR)
                            pending.push_back(make(KIND_FILE_OK, ERR_FILE_HDR, 0));
                        else
                            pending.push_back(make(KIND_ERROR, ERR_FILE_HDR, 0));
                    end
                end
                SEC_EV_HDR:
                begin
                    if (cnt < 4) open_tag = 32'(put_byte(64'(open_tag), cnt, b));
                    else if (cnt < 12) ev_number = put_byte(ev_number, cnt - 4, b);
                    else if (cnt < 20) ev_flags = put_byte(ev_flags, cnt - 12, b);
                    else if (cnt < 28) pay_size = put_byte(pay_size, cnt - 20, b);
                    else close_tag = put_byte(close_tag, cnt - 28, b);
                    cnt++;
                    if (cnt == 32)
                    begin
                        cnt = 0;
                        if ((open_tag & close_tag[31:0]) != TAG_EVENT_HDR)
                        begin
                            if (open_tag == TAG_FILE_TRL)
                                sec = SEC_FILE_TRL;
                            else
                                pending.push_back(make(KIND_ERROR, ERR_EVENT_HDR, 0));
                        end
                        else
                        begin
                            crc = '1;
                            in_bank_hdr = 1;
                            bank_idx = 0;
                            bank_left = 0;
                            sec = (pay_size == 0) ? SEC_EV_TRL : SEC_PAYLOAD;
                        end
                    end
                end
                SEC_PAYLOAD:
                begin
                    take_payload(b);
                end
                SEC_EV_TRL:
                begin
                    if (cnt < 4) open_tag = 32'(put_byte(64'(open_tag), cnt, b));
                    else if (cnt < 8) trl_crc = 32'(put_byte(64'(trl_crc), cnt - 4, b));
                    else if (cnt < 16) trl_size = put_byte(trl_size, cnt - 8, b);
                    else close_tag = put_byte(close_tag, cnt - 16, b);
                    cnt++;
                    if (cnt == 20)
                    begin
                        sec = SEC_EV_HDR;
                        cnt = 0;
                        // Tags and sizes are judged first, then the CRC, then the banks.
                        if ((open_tag & close_tag[31:0]) != TAG_EVENT_TRL
                            || pay_size != trl_size)
                            pending.push_back(make(KIND_ERROR, ERR_MISMATCH, 1));
                        else if (~crc != trl_crc)
                            pending.push_back(make(KIND_ERROR, ERR_CRC, 1));
                        else if (!in_bank_hdr || bank_idx != 0)
                            pending.push_back(make(KIND_ERROR, ERR_BANK, 1));
                        else
                            pending.push_back(make(KIND_EVENT_OK, ERR_FILE_HDR, 1));
                    end
                end
                SEC_FILE_TRL:
                begin
                    if (cnt >= 24) close_tag = put_byte(close_tag, cnt - 24, b);
                    cnt++;
                    if (cnt == 28)
                    begin
                        sec = SEC_DONE;
                        if ((open_tag & close_tag[31:0]) == TAG_FILE_TRL)
                            pending.push_back(make(KIND_EOF, ERR_FILE_HDR, 0));
                        else
                            pending.push_back(make(KIND_ERROR, ERR_END, 0));
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
        endtask

        // Compares one accepted result with the oldest prediction.
        task check_result(check_result_t got);
            check_result_t want;
            if (pending.size() == 0)
            begin
                report("result with nothing expected, kind", got.kind, 0);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) report("kind", got.kind, want.kind);
            if (got.error_code !== want.error_code)
                report("error_code", got.error_code, want.error_code);
            if (got.event_number !== want.event_number)
                report("event_number", got.event_number, want.event_number);
            if (got.user_flags !== want.user_flags)
                report("user_flags", got.user_flags, want.user_flags);
            if (got.length_bytes !== want.length_bytes)
                report("length_bytes", got.length_bytes, want.length_bytes);
            if (got.bank_flags !== want.bank_flags)
                report("bank_flags", got.bank_flags, want.bank_flags);
            if (got.bank_offset !== want.bank_offset)
                report("bank_offset", got.bank_offset, want.bank_offset);
            if (got.name_low !== want.name_low)
                report("name_low", got.name_low, want.name_low);
            if (got.name_high !== want.name_high)
                report("name_high", got.name_high, want.name_high);
            if (got.checksum !== want.checksum)
                report("checksum", got.checksum, want.checksum);
        endtask
    endclass

    // Ways to build an event; the bad ones each aim at one check of the block.
    typedef enum int {
        EV_GOOD,
        EV_BAD_CRC,
        EV_SIZE_MISMATCH,
        EV_BAD_TRL_TAG,
        EV_BANK_OVERRUN,
        EV_BANK_LEFTOVER,
        EV_BAD_HDR,
        EV_EMPTY
    } event_shape_t;

    logic clk;
    logic rst_n;

    esc_in_if  bytes_if ();
    esc_out_if res_if ();

    event_stream_checker u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (res_if)
    );

    stream_tracker tracker;

    // Each queued request holds the stream_end bit above the byte.
    bit [8:0] stream [$];
    int       send_idle;
    int       recv_idle;

    always #5 clk = ~clk;

    // Both monitors sample at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n && bytes_if.valid && bytes_if.ready)
        begin
            tracker.note_byte(bytes_if.byte_value, bytes_if.stream_end);
        end
    end

    always @(posedge clk)
    begin
        check_result_t r;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            r.kind = res_if.kind;
            r.error_code = res_if.error_code;
            r.event_number = res_if.event_number;
            r.user_flags = res_if.user_flags;
            r.length_bytes = res_if.length_bytes;
            r.bank_flags = res_if.bank_flags;
            r.bank_offset = res_if.bank_offset;
            r.name_low = res_if.name_low;
            r.name_high = res_if.name_high;
            r.checksum = res_if.checksum;
            tracker.check_result(r);
        end
    end

    // The result side stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    task push_le(bit [63:0] v, int n);
        for (int i = 0; i < n; i++)
        begin
            stream.push_back({1'b0, v[i*8 +: 8]});
        end
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Tags are split so that only their AND matches, which walks every bit.
    task push_tag_pair_open(bit [31:0] tag, output bit [31:0] mask);
        mask = $urandom;
        push_le(tag | mask, 4);
    endtask

    task build_file_header(bit good);
        bit [31:0] mask;
        bit [31:0] close;
        push_tag_pair_open(TAG_FILE_HDR, mask);
        push_le(rand64(), 8);
        for (int i = 0; i < 44; i++) stream.push_back({1'b0, 8'($urandom)});
        close = TAG_FILE_HDR | ~mask;
        if (!good) close[0] = 1'b0;
        push_le(close, 4);
    endtask

    task build_event(event_shape_t shape);
        bit [7:0]  pay [$];
        bit [31:0] mask;
        bit [31:0] close;
        bit [31:0] sum;
        bit [63:0] size;
        int        nbanks;
        int        dsize;
        nbanks = (shape == EV_EMPTY) ? 0 : $urandom_range(0, 3);
        for (int k = 0; k < nbanks; k++)
        begin
            // A rare large bank of 40 to 70 data bytes; its size still fits the low byte.
            dsize = ($urandom_range(19) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 5);
            for (int i = 0; i < 16; i++) pay.push_back(8'($urandom));
            for (int i = 0; i < 4; i++) pay.push_back(8'(dsize >> (8 * i)));
            for (int i = 0; i < dsize; i++) pay.push_back(8'($urandom));
        end
        if (shape == EV_BANK_OVERRUN)
        begin
            // The last bank claims more data than the payload holds.
            for (int i = 0; i < 16; i++) pay.push_back(8'($urandom));
            pay.push_back(8'd10);
            for (int i = 0; i < 3; i++) pay.push_back(8'd0);
            for (int i = 0; i < 3; i++) pay.push_back(8'($urandom));
        end
        if (shape == EV_BANK_LEFTOVER)
        begin
            repeat ($urandom_range(1, 19)) pay.push_back(8'($urandom));
        end
        size = pay.size();
        if (shape == EV_BAD_HDR)
        begin
            mask = $urandom;
            push_le(mask, 4);
            push_le(rand64(), 8);
            push_le(rand64(), 8);
            push_le(rand64(), 8);
            push_le(32'($urandom) & ~TAG_EVENT_HDR, 4);
            return;
        end
        push_tag_pair_open(TAG_EVENT_HDR, mask);
        push_le(rand64(), 8);
        push_le(rand64(), 8);
        push_le(size, 8);
        push_le(TAG_EVENT_HDR | ~mask, 4);
        sum = '1;
        foreach (pay[i])
        begin
            sum = crc32_next(sum, pay[i]);
            stream.push_back({1'b0, pay[i]});
        end
        sum = ~sum;
        if (shape == EV_BAD_CRC) sum[$urandom_range(31)] ^= 1'b1;
        if (shape == EV_SIZE_MISMATCH) size[$urandom_range(63)] ^= 1'b1;
        push_tag_pair_open(TAG_EVENT_TRL, mask);
        push_le(sum, 4);
        push_le(size, 8);
        close = TAG_EVENT_TRL | ~mask;
        if (shape == EV_BAD_TRL_TAG) close[2] = 1'b0;
        push_le(close, 4);
    endtask

    // Ends the file one of three ways, then adds bytes the stopped block ignores.
    task build_file_end();
        int how;
        how = $urandom_range(2);
        if (how == 2)
        begin
            stream.push_back({1'b1, 8'($urandom)});
        end
        else
        begin
            push_le(TAG_FILE_TRL, 4);
            for (int i = 0; i < 52; i++) stream.push_back({1'b0, 8'($urandom)});
            push_le(how == 0 ? (TAG_FILE_TRL | $urandom) : (TAG_FILE_TRL & ~32'h4), 4);
        end
        repeat (5) stream.push_back(9'($urandom));
    endtask

    task send_request(bit [8:0] item);
        if ($urandom_range(99) < send_idle)
        begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        bytes_if.valid <= 1'b1;
        bytes_if.byte_value <= item[7:0];
        bytes_if.stream_end <= item[8];
        @(posedge clk);
        while (!bytes_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Sends the queued requests, moving through the three idling phases.
    task send_stream();
        int total;
        int sent;
        total = stream.size();
        sent = 0;
        while (stream.size() != 0)
        begin
            if (sent < total / 3)
            begin
                send_idle = 33;
                recv_idle = 82;
            end
            else if (sent < 2 * total / 3)
            begin
                send_idle = 82;
                recv_idle = 33;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_request(stream.pop_front());
            sent++;
        end
        bytes_if.valid <= 1'b0;
    endtask

    task wait_drained();
        while (tracker.pending.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        #1ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        event_shape_t shape;
        int           first_count;
        tracker = new();
        clk = 1'b0;
        rst_n = 1'b0;
        bytes_if.valid = 1'b0;
        bytes_if.byte_value = 8'd0;
        bytes_if.stream_end = 1'b0;
        res_if.ready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening: every way an event can pass or fail once.
        build_file_header($urandom_range(3) != 0);
        build_event(EV_EMPTY);
        build_event(EV_BAD_HDR);
        build_event(EV_BAD_CRC);
        build_event(EV_SIZE_MISMATCH);
        build_event(EV_BAD_TRL_TAG);
        build_event(EV_BANK_OVERRUN);
        build_event(EV_BANK_LEFTOVER);
        build_event(EV_GOOD);
        first_count = stream.size();
        send_stream();

        // Hold the sender until every prediction so far has come back.
        wait_drained();
        repeat (4) @(negedge clk);

        // Random part: mostly well-formed events, at least one, until the
        // whole run has about 550 byte requests.
        while (stream.size() == 0 || first_count + stream.size() < 550)
        begin
            shape = ($urandom_range(99) < 60) ? EV_GOOD
                                              : event_shape_t'($urandom_range(1, 7));
            build_event(shape);
        end
        build_file_end();
        send_stream();

        wait_drained();
        repeat (20) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
